### sv/tpm_pkg.sv
// Shared types and constants for the text pagination marker.
// No dependencies; every other file of the block refers to this package.
package tpm_pkg;

   // usable row width before margins, in pixels
   localparam logic [11:0] USABLE_FULL = 12'd320;

   // character codes that get special handling
   localparam logic [15:0] CODE_TAB   = 16'h0009;
   localparam logic [15:0] CODE_LF    = 16'h000A;
   localparam logic [15:0] CODE_CR    = 16'h000D;
   localparam logic [15:0] CODE_SPACE = 16'h0020;

   // a checkpoint falls on source lines 1, 65, 129, ...
   localparam int unsigned CHECK_BITS = 6;
   localparam logic [CHECK_BITS-1:0] CHECK_PHASE = 6'd1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARGIN         = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_ROWS      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALLBACK_WIDTH = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_SIZE      = 8'd3;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // mark buffer in the back end
   localparam int unsigned MARK_DEPTH = 4;
   localparam int unsigned MARK_PTR_W = $clog2(MARK_DEPTH);
   localparam int unsigned MARK_CNT_W = $clog2(MARK_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_START,
      OP_NEWLINE,
      OP_GLYPH
   } op_type;

   typedef enum logic {
      KIND_PAGE  = 1'b0,
      KIND_CHECK = 1'b1
   } kind_type;

   typedef struct packed {
      logic [7:0]  margin;
      logic [7:0]  page_rows;
      logic [7:0]  fallback_width;
      logic [31:0] text_size;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  char_width;
      logic        check_due;
      logic        below_eof;
      logic [31:0] offset;
      logic [31:0] line;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] mark_offset;
      logic [31:0] line_number;
      logic        last_of_run;
   } mark_type;

endpackage

### sv/tpm_if.sv
// Channel interfaces of the text pagination marker: request, response, CSR write.
// Depends on tpm_pkg for the CSR index width.
interface tpm_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [15:0]        code;
   logic signed [7:0]  glyph_width;
   logic [31:0]        char_offset;
   logic [31:0]        next_offset;
   logic [31:0]        src_line;

   modport source (output valid, cmd, code, glyph_width, char_offset, next_offset,
                   src_line, input ready);
   modport sink   (input valid, cmd, code, glyph_width, char_offset, next_offset,
                   src_line, output ready);
endinterface

interface tpm_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] mark_offset;
   logic [31:0] line_number;
   logic        last_of_run;

   modport source (output valid, kind, mark_offset, line_number, last_of_run,
                   input ready);
   modport sink   (input valid, kind, mark_offset, line_number, last_of_run,
                   output ready);
endinterface

interface tpm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tpm_pkg::CSR_INDEX_W-1:0]     index;
   logic [31:0]                         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/tpm_front.sv
// Front end: accepts requests, drops codes without effect, classifies the rest.
// Depends on tpm_pkg and tpm_req_if; feeds tpm_queue.
module tpm_front (
   tpm_req_if.sink            req_ch,
   input  tpm_pkg::cfg_type   cfg,
   output logic               push_valid,
   input  logic               push_ready,
   output tpm_pkg::item_type  push_item
);

   logic [15:0] code_eff;
   logic        keep;

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid && keep;

   always_comb begin
      code_eff = (req_ch.code == tpm_pkg::CODE_TAB) ? tpm_pkg::CODE_SPACE : req_ch.code;
      keep                 = 1'b1;
      push_item.op         = tpm_pkg::OP_GLYPH;
      push_item.char_width = '0;
      push_item.check_due  = 1'b0;
      push_item.below_eof  = 1'b0;
      push_item.offset     = req_ch.char_offset;
      push_item.line       = req_ch.src_line;
      if (!req_ch.cmd) begin
         push_item.op     = tpm_pkg::OP_START;
         push_item.offset = req_ch.next_offset;
         push_item.line   = 32'd1;
      end else if (req_ch.code == tpm_pkg::CODE_CR) begin
         keep = 1'b0;
      end else if (req_ch.code == tpm_pkg::CODE_LF) begin
         push_item.op        = tpm_pkg::OP_NEWLINE;
         push_item.offset    = req_ch.next_offset;
         push_item.check_due =
            (req_ch.src_line[tpm_pkg::CHECK_BITS-1:0] == tpm_pkg::CHECK_PHASE);
         push_item.below_eof = (req_ch.next_offset < cfg.text_size);
      end else if (code_eff < tpm_pkg::CODE_SPACE) begin
         keep = 1'b0;
      end else begin
         // non-positive glyph width falls back to the configured fallback width
         push_item.char_width = (req_ch.glyph_width > 8'sd0) ?
                                req_ch.glyph_width[7:0] : cfg.fallback_width;
      end
   end

endmodule

### sv/tpm_queue.sv
// Short queue between front and back of the text pagination marker.
// Depends on tpm_pkg for the item type and depth.
module tpm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  tpm_pkg::item_type  in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output tpm_pkg::item_type  out_item
);

   tpm_pkg::item_type                 slot_ff [tpm_pkg::QUEUE_DEPTH];
   logic [tpm_pkg::QUEUE_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [tpm_pkg::QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                              push, pop;

   assign in_ready  = (cnt_ff != tpm_pkg::QUEUE_CNT_W'(tpm_pkg::QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + tpm_pkg::QUEUE_CNT_W'(push) - tpm_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_item;
      end
   end

endmodule

### sv/tpm_back.sv
// Back end: row/page tracking, duplicate suppression and the mark buffer.
// Depends on tpm_pkg and tpm_rsp_if; fed by tpm_queue.
module tpm_back (
   input  logic               clock,
   input  logic               reset,
   input  tpm_pkg::cfg_type   cfg,
   input  logic               item_valid,
   output logic               item_ready,
   input  tpm_pkg::item_type  item,
   tpm_rsp_if.source          rsp_ch
);

   logic [9:0]   row_width_ff, row_width_in;
   logic [7:0]   row_in_page_ff, row_in_page_in;
   logic [31:0]  last_page_offset_ff, last_page_offset_in;
   logic [31:0]  last_page_line_ff, last_page_line_in;
   logic [31:0]  last_check_offset_ff, last_check_offset_in;
   logic [31:0]  last_check_line_ff, last_check_line_in;

   tpm_pkg::mark_type                 mark_ff [tpm_pkg::MARK_DEPTH];
   logic [tpm_pkg::MARK_PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [tpm_pkg::MARK_CNT_W-1:0]    cnt_ff, cnt_in;

   logic                 take, pop;
   logic [7:0]           row_inc, row_next;
   logic                 page_full;
   logic [11:0]          width_sum;
   logic signed [11:0]   usable_width;
   logic                 wrap;
   logic                 page_dup, check_dup;
   logic                 v0, v1;
   tpm_pkg::mark_type    c0, c1, e0, e1;
   logic [1:0]           n_marks;

   // take an item only when the buffer has room for two marks
   assign item_ready = (cnt_ff <= tpm_pkg::MARK_CNT_W'(tpm_pkg::MARK_DEPTH - 2));
   assign take       = item_valid && item_ready;
   assign pop        = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.valid       = (cnt_ff != '0);
   assign rsp_ch.kind        = mark_ff[rd_ff].kind;
   assign rsp_ch.mark_offset = mark_ff[rd_ff].mark_offset;
   assign rsp_ch.line_number = mark_ff[rd_ff].line_number;
   assign rsp_ch.last_of_run = mark_ff[rd_ff].last_of_run;

   always_comb begin
      row_inc   = row_in_page_ff + 8'd1;
      page_full = (row_inc >= cfg.page_rows);
      row_next  = page_full ? 8'd0 : row_inc;
      width_sum = {2'b00, row_width_ff} + {4'b0000, item.char_width};
      usable_width = $signed(tpm_pkg::USABLE_FULL) - $signed({3'b000, cfg.margin, 1'b0});
      wrap      = (row_width_ff != 10'd0) && ($signed(width_sum) > usable_width);
      page_dup  = (item.offset == last_page_offset_ff) && (item.line == last_page_line_ff);
      check_dup = (item.offset == last_check_offset_ff) &&
                  (item.line == last_check_line_ff);

      row_width_in         = row_width_ff;
      row_in_page_in       = row_in_page_ff;
      last_page_offset_in  = last_page_offset_ff;
      last_page_line_in    = last_page_line_ff;
      last_check_offset_in = last_check_offset_ff;
      last_check_line_in   = last_check_line_ff;

      v0 = 1'b0;
      v1 = 1'b0;
      c0 = '{kind: tpm_pkg::KIND_CHECK, mark_offset: item.offset,
             line_number: item.line, last_of_run: 1'b0};
      c1 = '{kind: tpm_pkg::KIND_PAGE, mark_offset: item.offset,
             line_number: item.line, last_of_run: 1'b1};

      if (take) begin
         case (item.op)
            tpm_pkg::OP_START: begin
               // page mark first, then checkpoint, never suppressed
               row_width_in         = '0;
               row_in_page_in       = '0;
               last_page_offset_in  = item.offset;
               last_page_line_in    = item.line;
               last_check_offset_in = item.offset;
               last_check_line_in   = item.line;
               v0 = 1'b1;
               v1 = 1'b1;
               c0.kind = tpm_pkg::KIND_PAGE;
               c1.kind = tpm_pkg::KIND_CHECK;
            end
            tpm_pkg::OP_NEWLINE: begin
               row_width_in   = '0;
               row_in_page_in = row_next;
               if (item.check_due && !check_dup) begin
                  v0 = 1'b1;
                  last_check_offset_in = item.offset;
                  last_check_line_in   = item.line;
               end
               if (page_full && item.below_eof && !page_dup) begin
                  v1 = 1'b1;
                  last_page_offset_in = item.offset;
                  last_page_line_in   = item.line;
               end
            end
            tpm_pkg::OP_GLYPH: begin
               if (wrap) begin
                  row_in_page_in = row_next;
                  row_width_in   = 10'(item.char_width);
                  if (page_full && !page_dup) begin
                     v1 = 1'b1;
                     last_page_offset_in = item.offset;
                     last_page_line_in   = item.line;
                  end
               end else begin
                  row_width_in = width_sum[9:0];
               end
            end
            default: begin
            end
         endcase
      end

      // pack the valid marks at the buffer tail
      n_marks = {1'b0, v0} + {1'b0, v1};
      e0 = v0 ? c0 : c1;
      e0.last_of_run = !(v0 && v1);
      e1 = c1;
      e1.last_of_run = 1'b1;

      wr_in  = wr_ff + tpm_pkg::MARK_PTR_W'(n_marks);
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + tpm_pkg::MARK_CNT_W'(n_marks) - tpm_pkg::MARK_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff         <= '0;
         row_in_page_ff       <= '0;
         last_page_offset_ff  <= '0;
         last_page_line_ff    <= '0;
         last_check_offset_ff <= '0;
         last_check_line_ff   <= '0;
         wr_ff                <= '0;
         rd_ff                <= '0;
         cnt_ff               <= '0;
      end else begin
         row_width_ff         <= row_width_in;
         row_in_page_ff       <= row_in_page_in;
         last_page_offset_ff  <= last_page_offset_in;
         last_page_line_ff    <= last_page_line_in;
         last_check_offset_ff <= last_check_offset_in;
         last_check_line_ff   <= last_check_line_in;
         wr_ff                <= wr_in;
         rd_ff                <= rd_in;
         cnt_ff               <= cnt_in;
      end
      if (n_marks != 2'd0) begin
         mark_ff[wr_ff] <= e0;
      end
      if (n_marks == 2'd2) begin
         mark_ff[wr_ff + 1'b1] <= e1;
      end
   end

endmodule

### sv/text_pagination_marker.sv
// Top level of the text pagination marker: CSR bank, front end, queue, back end.
// Depends on tpm_pkg, tpm_if, tpm_front, tpm_queue and tpm_back.
//
// Greedy line-wrap pagination over a stream of decoded characters. A start
// request clears the row state and always yields a page mark and a line
// checkpoint at the data start offset, line 1. Each character request adds
// its glyph width (or the fallback width when the glyph width is not
// positive) to the current visual row; a non-empty row that would exceed
// 320 - 2*margin pixels starts a new row, and a newline ends the row too.
// Every row that fills a page yields a page mark (on newlines only below
// the text size), and a newline on source lines 1, 65, 129, ... yields a
// checkpoint. A mark equal to the last one of its kind is dropped. Carriage
// returns and other control codes are discarded in the front end, tabs count
// as spaces. Throughput: one request per cycle, set by the row/page update in
// the back end; when requests produce marks faster than one per cycle, the
// response port (one mark per cycle) sets the rate and back-pressure reaches
// the request port through the two-entry queue and the four-entry mark
// buffer. An accepted request is registered in the queue; the back end takes
// it once the mark buffer has room and writes its marks into that buffer,
// from which the response port offers them. CSR writes are taken every cycle
// (csr_ch.ready is constant high) and must only happen while no request is in flight.
module text_pagination_marker (
   input  logic        clock,
   input  logic        reset,
   tpm_req_if.sink     req_ch,
   tpm_rsp_if.source   rsp_ch,
   tpm_csr_if.sink     csr_ch
);

   tpm_pkg::cfg_type   cfg_ff, cfg_in;

   logic               push_valid, push_ready;
   tpm_pkg::item_type  push_item;
   logic               item_valid, item_ready;
   tpm_pkg::item_type  item;

   // CSR bank: always ready, ignore writes to unknown indexes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            tpm_pkg::CSR_MARGIN:         cfg_in.margin         = csr_ch.data[7:0];
            tpm_pkg::CSR_PAGE_ROWS:      cfg_in.page_rows      = csr_ch.data[7:0];
            tpm_pkg::CSR_FALLBACK_WIDTH: cfg_in.fallback_width = csr_ch.data[7:0];
            tpm_pkg::CSR_TEXT_SIZE:      cfg_in.text_size      = csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.margin         <= 8'd0;
         cfg_ff.page_rows      <= 8'd1;
         cfg_ff.fallback_width <= 8'd0;
         cfg_ff.text_size      <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify requests, drop the ones that change nothing
   tpm_front u_front (
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decouple the front from the back
   tpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (item_valid),
      .out_ready (item_ready),
      .out_item  (item)
   );

   // advance rows and pages, emit marks
   tpm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_ch     (rsp_ch)
   );

endmodule

### sim/tb.sv
// Testbench for text_pagination_marker: a random text stream over several settings.
// Builds the expected page marks and checkpoints from its own pagination model.
// Depends on tpm_pkg, the channel interfaces in tpm_if and the block itself.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HALF_PERIOD     = 10;
   localparam int unsigned RESET_CYCLES    = 5;
   // slack left after the last expected mark has arrived
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned DRAIN_LIMIT     = 20000;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned ITEMS_PER_PHASE = 64;
   localparam int unsigned RUN_LIMIT_NS    = 10_000_000;

   typedef struct packed {
      logic              cmd;
      logic [15:0]       code;
      logic signed [7:0] glyph_width;
      logic [31:0]       char_offset;
      logic [31:0]       next_offset;
      logic [31:0]       src_line;
   } char_req_type;

   // stall patterns of the mark receiver
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_CHOKE,
      RX_CADENCE
   } rx_pattern_type;

   logic clock = 1'b0;
   logic reset;

   tpm_req_if req_ch ();
   tpm_rsp_if rsp_ch ();
   tpm_csr_if csr_ch ();

   text_pagination_marker dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Pagination model: register copy, row state and the last mark of
   // each kind, which is what duplicate suppression compares against.
   // ------------------------------------------------------------------
   tpm_pkg::cfg_type  cfg;
   logic [9:0]        row_width;
   logic [7:0]        row_in_page;
   logic [31:0]       last_page_off;
   logic [31:0]       last_page_line;
   logic [31:0]       last_check_off;
   logic [31:0]       last_check_line;

   tpm_pkg::mark_type pending_marks[$];
   tpm_pkg::mark_type oldest;
   int unsigned       mismatches;
   int unsigned       items_sent;
   int                burst_left;
   int                pattern_left = 0;
   rx_pattern_type    rx_pattern = RX_OPEN;

   // Close the current visual row; report whether it filled a page.
   // A page size of 0 behaves like 1 since the compare is "reached or passed".
   function automatic logic close_row();
      row_width   = '0;
      row_in_page = row_in_page + 8'd1;
      if (row_in_page >= cfg.page_rows) begin
         row_in_page = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Append a mark unless it repeats the last one of its kind.
   task automatic add_mark(ref tpm_pkg::mark_type run[$], input tpm_pkg::kind_type kind,
                           input logic [31:0] off, input logic [31:0] line);
      if (kind == tpm_pkg::KIND_PAGE) begin
         if (off == last_page_off && line == last_page_line) return;
         last_page_off  = off;
         last_page_line = line;
      end else begin
         if (off == last_check_off && line == last_check_line) return;
         last_check_off  = off;
         last_check_line = line;
      end
      run.push_back('{kind: kind, mark_offset: off, line_number: line, last_of_run: 1'b0});
   endtask

   // Advance the model by one accepted request and queue the marks it yields.
   task automatic paginate(input char_req_type r);
      tpm_pkg::mark_type run[$];
      logic [15:0]       code;
      int                char_w;
      int                usable_w;
      logic              page_full;

      code = r.code;
      if (r.cmd == 1'b0) begin
         // a start always yields both marks at the data start, line 1
         row_width       = '0;
         row_in_page     = '0;
         last_page_off   = r.next_offset;
         last_page_line  = 32'd1;
         last_check_off  = r.next_offset;
         last_check_line = 32'd1;
         run.push_back('{kind: tpm_pkg::KIND_PAGE, mark_offset: r.next_offset,
                         line_number: 32'd1, last_of_run: 1'b0});
         run.push_back('{kind: tpm_pkg::KIND_CHECK, mark_offset: r.next_offset,
                         line_number: 32'd1, last_of_run: 1'b0});
      end else if (code == tpm_pkg::CODE_CR) begin
         // carriage return leaves no trace
      end else if (code == tpm_pkg::CODE_LF) begin
         page_full = close_row();
         if (r.src_line[tpm_pkg::CHECK_BITS-1:0] == tpm_pkg::CHECK_PHASE)
            add_mark(run, tpm_pkg::KIND_CHECK, r.next_offset, r.src_line);
         if (page_full && r.next_offset < cfg.text_size)
            add_mark(run, tpm_pkg::KIND_PAGE, r.next_offset, r.src_line);
      end else begin
         if (code == tpm_pkg::CODE_TAB) code = tpm_pkg::CODE_SPACE;
         if (code >= tpm_pkg::CODE_SPACE) begin
            char_w   = (r.glyph_width > 0) ? int'(r.glyph_width) : int'(cfg.fallback_width);
            // margins above 160 push the usable width below zero
            usable_w = int'(tpm_pkg::USABLE_FULL) - 2 * int'(cfg.margin);
            if (row_width != '0 && int'(row_width) + char_w > usable_w) begin
               if (close_row())
                  add_mark(run, tpm_pkg::KIND_PAGE, r.char_offset, r.src_line);
            end
            row_width = row_width + 10'(char_w);
         end
      end
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) pending_marks.push_back(run[i]);
   endtask

   // ------------------------------------------------------------------
   // Request side: drive at the falling edge, accept at the rising edge.
   // ------------------------------------------------------------------
   task automatic req_idle(input int n);
      repeat (n) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   // Send one request, opening a new burst after a random gap when the
   // current burst is used up; a third of the gaps are empty.
   task automatic send_char(input char_req_type r);
      if (burst_left == 0) begin
         req_idle(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= r.cmd;
      req_ch.code        <= r.code;
      req_ch.glyph_width <= r.glyph_width;
      req_ch.char_offset <= r.char_offset;
      req_ch.next_offset <= r.next_offset;
      req_ch.src_line    <= r.src_line;
      do @(posedge clock); while (!req_ch.ready);
      paginate(r);
      // carriage returns are simply dropped and do not count as stimulus
      if (!(r.cmd && r.code == tpm_pkg::CODE_CR)) items_sent++;
   endtask

   // Hold off requests until every mark is in, then let the pipe empty out.
   task automatic await_marks();
      int waited;
      req_idle(1);
      waited = 0;
      while (pending_marks.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [tpm_pkg::CSR_INDEX_W-1:0] index,
                            input logic [31:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (index)
         tpm_pkg::CSR_MARGIN:         cfg.margin         = data[7:0];
         tpm_pkg::CSR_PAGE_ROWS:      cfg.page_rows      = data[7:0];
         tpm_pkg::CSR_FALLBACK_WIDTH: cfg.fallback_width = data[7:0];
         tpm_pkg::CSR_TEXT_SIZE:      cfg.text_size      = data;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Reprogram all registers once the block is quiet. The 8-bit registers
   // get random upper bits, which the block must drop.
   task automatic configure(input logic [7:0] margin_px, input logic [7:0] rows,
                            input logic [7:0] fallback, input logic [31:0] size);
      logic [31:0] junk;
      await_marks();
      junk = $urandom;
      write_csr(tpm_pkg::CSR_MARGIN, {junk[31:8], margin_px});
      junk = $urandom;
      write_csr(tpm_pkg::CSR_PAGE_ROWS, {junk[31:8], rows});
      junk = $urandom;
      write_csr(tpm_pkg::CSR_FALLBACK_WIDTH, {junk[31:8], fallback});
      write_csr(tpm_pkg::CSR_TEXT_SIZE, size);
   endtask

   function automatic char_req_type char_item(input logic [15:0] code,
                                              input logic signed [7:0] gw,
                                              input logic [31:0] coff,
                                              input logic [31:0] noff,
                                              input logic [31:0] sline);
      char_req_type r;
      r.cmd         = 1'b1;
      r.code        = code;
      r.glyph_width = gw;
      r.char_offset = coff;
      r.next_offset = noff;
      r.src_line    = sline;
      return r;
   endfunction

   // Start request; everything but the data start offset is don't-care.
   function automatic char_req_type text_start(input logic [31:0] noff);
      char_req_type r;
      r.cmd         = 1'b0;
      r.code        = 16'($urandom);
      r.glyph_width = 8'($urandom);
      r.char_offset = $urandom;
      r.next_offset = noff;
      r.src_line    = 32'd1;
      return r;
   endfunction

   // A plausible stretch of text: rising offsets, line count bumped on each
   // newline, starting at line 1, just short of a checkpoint line or anywhere.
   task automatic send_text_run(input logic with_start);
      char_req_type r;
      logic [31:0]  off;
      logic [31:0]  line;
      logic [31:0]  rnd;
      int           roll;

      rnd = $urandom;
      off = ($urandom_range(0, 2) == 0) ? cfg.text_size - $urandom_range(0, 80) : $urandom;
      case ($urandom_range(0, 2))
         0:       line = 32'd1;
         1:       line = {rnd[31:6], 6'd0} - $urandom_range(0, 3);
         default: line = $urandom;
      endcase
      if (with_start) send_char(text_start(off));
      repeat ($urandom_range(4, 40)) begin
         roll          = $urandom_range(0, 99);
         r.cmd         = 1'b1;
         r.char_offset = off;
         r.next_offset = off + $urandom_range(1, 4);
         off           = r.next_offset;
         r.glyph_width = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 40));
         if (roll < 55) r.code = 16'($urandom_range(16'h21, 16'h7E));
         else if (roll < 65) r.code = 16'($urandom_range(16'h80, 16'hFFFF));
         else if (roll < 75) r.code = tpm_pkg::CODE_SPACE;
         else if (roll < 86) begin
            r.code = tpm_pkg::CODE_LF;
            line   = line + 32'd1;
         end
         else if (roll < 90) r.code = tpm_pkg::CODE_TAB;
         else if (roll < 94) r.code = tpm_pkg::CODE_CR;
         else r.code = 16'($urandom_range(0, 31));
         r.src_line = line;
         send_char(r);
      end
   endtask

   // Loose requests. Offsets and lines come often from a small pool so that
   // repeated marks (and their suppression) turn up.
   task automatic send_noise();
      char_req_type r;
      logic [31:0]  spots [4];

      spots = '{32'd0, 32'd1, cfg.text_size, 32'hFFFF_FFFF};
      repeat ($urandom_range(1, 6)) begin
         r.cmd = ($urandom_range(0, 7) != 0);
         case ($urandom_range(0, 3))
            0:       r.code = 16'($urandom);
            1:       r.code = tpm_pkg::CODE_LF;
            2:       r.code = 16'($urandom_range(0, 31));
            default: r.code = 16'($urandom_range(16'h20, 16'hFFFF));
         endcase
         r.glyph_width = 8'($urandom);
         r.char_offset = $urandom_range(0, 1) ? spots[$urandom_range(0, 3)] : $urandom;
         r.next_offset = $urandom_range(0, 1) ? spots[$urandom_range(0, 3)] : $urandom;
         r.src_line    = $urandom_range(0, 1) ? $urandom_range(0, 2) * 64 + 1 : $urandom;
         send_char(r);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Straight out of reset, with reset register values: a wrap at offset 0,
   // line 0 matches the cleared last-page state and must be dropped, while
   // a newline checkpoint at line 1 still goes out. A text size of 0 blocks
   // the newline page mark.
   task automatic test_before_start();
      send_char(char_item(16'h0041, 8'sd127, 32'd0, 32'd1, 32'd0));
      send_char(char_item(16'h0042, 8'sd127, 32'd1, 32'd2, 32'd0));
      send_char(char_item(16'h0043, 8'sd127, 32'd0, 32'd3, 32'd0));
      send_char(char_item(tpm_pkg::CODE_LF, 8'sd0, 32'd3, 32'd0, 32'd1));
   endtask

   // Starts are never suppressed, even back to back; a checkpoint on the
   // same spot right after a start is.
   task automatic test_start_marks();
      send_char(text_start(32'd100));
      send_char(text_start(32'd100));
      send_char(char_item(tpm_pkg::CODE_LF, 8'sd5, 32'd99, 32'd100, 32'd1));
   endtask

   // Every row is a page here. Cover fallback width, the glyph width
   // extremes, carriage return, tab, other control codes, the top code unit
   // and newline checkpoints including the topmost checkpoint line.
   task automatic test_widths_and_codes();
      configure(8'd0, 8'd0, 8'd255, 32'hFFFF_FFFF);
      send_char(char_item(16'h0061, 8'sd0, 32'd200, 32'd201, 32'd7));
      send_char(char_item(16'h0062, 8'sh80, 32'd201, 32'd202, 32'd7));
      send_char(char_item(tpm_pkg::CODE_CR, 8'sd127, 32'd202, 32'd203, 32'd7));
      send_char(char_item(tpm_pkg::CODE_TAB, 8'sd127, 32'd203, 32'd204, 32'd7));
      send_char(char_item(16'h001F, 8'sd127, 32'd204, 32'd205, 32'd7));
      send_char(char_item(16'hFFFF, 8'sd127, 32'd205, 32'd207, 32'd7));
      send_char(char_item(tpm_pkg::CODE_LF, 8'sd0, 32'd207, 32'd500, 32'd65));
      send_char(char_item(tpm_pkg::CODE_LF, 8'sd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                          32'hFFFF_FFC1));
      send_char(char_item(tpm_pkg::CODE_LF, 8'sd0, 32'hFFFF_FFFF, 32'd0, 32'd0));
   endtask

   // Margin 255 leaves a negative usable width: zero-width glyphs with no
   // fallback never wrap an empty row, anything wider on a non-empty row does.
   task automatic test_wide_margin();
      configure(8'd255, 8'd255, 8'd0, 32'd0);
      send_char(text_start(32'd1000));
      send_char(char_item(16'h0030, 8'sd0, 32'd1000, 32'd1001, 32'd1));
      send_char(char_item(16'h0031, 8'sd0, 32'd1001, 32'd1002, 32'd1));
      send_char(char_item(16'h0032, 8'sd1, 32'd1002, 32'd1003, 32'd1));
      send_char(char_item(16'h0033, 8'sd1, 32'd1003, 32'd1004, 32'd1));
      send_char(char_item(tpm_pkg::CODE_LF, 8'sd1, 32'd1004, 32'd1005, 32'd2));
   endtask

   // Random text over several settings, extremes first. Mostly proper runs
   // opened by a start, then loose requests and runs with no start at all.
   task automatic test_random_text();
      int unsigned target;
      int          roll;

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: configure(8'd0, 8'd1, 8'd0, 32'hFFFF_FFFF);
            1: configure(8'd160, 8'd2, 8'd255, $urandom);
            2: configure(8'd255, 8'd0, 8'($urandom), 32'd0);
            3: configure(8'($urandom_range(0, 160)), 8'd255, 8'($urandom), $urandom);
            default: configure(8'($urandom_range(0, 120)), 8'($urandom_range(1, 5)),
                               8'($urandom_range(0, 40)), $urandom);
         endcase
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            roll = $urandom_range(0, 9);
            if (roll < 7) send_text_run(1'b1);
            else if (roll < 9) send_noise();
            else send_text_run(1'b0);
            // now and then hold the stream until every mark is back
            if ($urandom_range(0, 9) == 0) await_marks();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Mark receiver: pick a new stall pattern whenever the current one runs out.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         rx_pattern   = rx_pattern_type'($urandom_range(0, 3));
         pattern_left = $urandom_range(8, 64);
      end
      pattern_left--;
      case (rx_pattern)
         RX_OPEN:  rsp_ch.ready <= 1'b1;
         RX_COIN:  rsp_ch.ready <= 1'($urandom_range(0, 1));
         RX_CHOKE: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         default:  rsp_ch.ready <= (pattern_left % 3 != 0);
      endcase
   end

   // Compare each accepted mark with the oldest one the model predicted.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_marks.size() == 0) begin
            $error("unexpected mark: kind %0d offset 0x%08h line %0d",
                   rsp_ch.kind, rsp_ch.mark_offset, rsp_ch.line_number);
            mismatches++;
         end else begin
            oldest = pending_marks.pop_front();
            if (rsp_ch.kind !== oldest.kind) begin
               $error("kind: expected %0d, got %0d", oldest.kind, rsp_ch.kind);
               mismatches++;
            end
            if (rsp_ch.mark_offset !== oldest.mark_offset) begin
               $error("mark_offset: expected 0x%08h, got 0x%08h",
                      oldest.mark_offset, rsp_ch.mark_offset);
               mismatches++;
            end
            if (rsp_ch.line_number !== oldest.line_number) begin
               $error("line_number: expected %0d, got %0d",
                      oldest.line_number, rsp_ch.line_number);
               mismatches++;
            end
            if (rsp_ch.last_of_run !== oldest.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d",
                      oldest.last_of_run, rsp_ch.last_of_run);
               mismatches++;
            end
         end
      end
   end

   initial begin
      // known values on every request and CSR input from time zero
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = 1'b0;
      req_ch.code        = '0;
      req_ch.glyph_width = '0;
      req_ch.char_offset = '0;
      req_ch.next_offset = '0;
      req_ch.src_line    = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;

      // model state after reset
      cfg             = '{margin: 8'd0, page_rows: 8'd1, fallback_width: 8'd0,
                          text_size: 32'd0};
      row_width       = '0;
      row_in_page     = '0;
      last_page_off   = '0;
      last_page_line  = '0;
      last_check_off  = '0;
      last_check_line = '0;
      mismatches      = 0;
      items_sent      = 0;
      burst_left      = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_before_start();
      test_start_marks();
      test_widths_and_codes();
      test_wide_margin();
      test_random_text();

      await_marks();
      if (pending_marks.size() != 0) begin
         $error("%0d expected marks never arrived", pending_marks.size());
         mismatches++;
      end
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(RUN_LIMIT_NS);
      $error("run timed out with %0d marks outstanding", pending_marks.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
